@@ src/fenw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fenw_pkg
// Shared types and constants of the binary indexed tree block.
// ----------------------------------------------------------------------------
package fenw_pkg;

  // Field widths
  localparam int unsigned IdxW  = 11;
  localparam int unsigned DataW = 32;
  // Walk position: an add may step one node past the largest index
  localparam int unsigned PosW  = IdxW + 1;

  // Defaults
  localparam int unsigned EntriesDefault = 1024;
  localparam logic [IdxW-1:0] TopIndexReset = IdxW'(1024);

  // Action codes
  localparam logic ActAdd   = 1'b0;
  localparam logic ActQuery = 1'b1;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StWalk  = 3'b100
  } state_e;

  // Per-node decision of the tree walk
  typedef struct packed {
    logic            active;    // node takes part in the walk
    logic            in_range;  // node exists in the store
    logic [PosW-1:0] next_pos;  // following node of the walk
  } node_info_t;

endpackage
`default_nettype wire

@@ src/fenw_node_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fenw_node_step
// One step of the tree walk: decides whether the current node is visited
// and computes the next node (up for an add, down for a query).
// ----------------------------------------------------------------------------
module fenw_node_step #(
  parameter int unsigned ENTRIES = fenw_pkg::EntriesDefault
) (
  input  logic [fenw_pkg::PosW-1:0] pos_i,
  input  logic                      query_i,
  input  logic [fenw_pkg::IdxW-1:0] limit_i,
  output fenw_pkg::node_info_t      info_o
);

  logic [fenw_pkg::PosW-1:0] low_bit;

  // Lowest set bit of the position
  assign low_bit = pos_i & (~pos_i + fenw_pkg::PosW'(1));

  always_comb begin
    info_o.in_range = (32'(pos_i) <= 32'(ENTRIES));
    if (pos_i == '0) begin
      info_o.active = 1'b0;
    end else if (query_i) begin
      info_o.active = 1'b1;
    end else begin
      info_o.active = (pos_i <= {1'b0, limit_i});
    end
    info_o.next_pos = query_i ? (pos_i - low_bit) : (pos_i + low_bit);
  end

endmodule
`default_nettype wire

@@ src/fenwick_point_add_prefix_sum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fenwick_point_add_prefix_sum
// Binary indexed tree over signed 32-bit partial sums held in one RAM.
// An item is accepted in the idle state, then the walk state visits each
// node in turn and ends in a closing step; a walk visits at most
// log2(ENTRIES) + 1 nodes (11). With the single RAM read-modify-write per
// node, a new item is taken only once the walk is over; a stalled result
// holds a query in its closing step. Reset: a clearing pass writes zero to
// all ENTRIES words, one per cycle; no item is accepted until it ends.
// ----------------------------------------------------------------------------
module fenwick_point_add_prefix_sum #(
  parameter int unsigned ENTRIES = fenw_pkg::EntriesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [fenw_pkg::IdxW-1:0]         cfg_wdata_i,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [fenw_pkg::IdxW-1:0]         index_i,
  input  logic signed [fenw_pkg::DataW-1:0] delta_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fenw_pkg::DataW-1:0] prefix_sum_o
);

  localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned PosW  = fenw_pkg::PosW;
  localparam int unsigned DataW = fenw_pkg::DataW;
  localparam int unsigned ExtW  = (AW > PosW) ? AW : PosW;

  // Store address of a one-based node position
  function automatic logic [AW-1:0] node_addr(input logic [PosW-1:0] p);
    logic [ExtW-1:0] e;
    e = ExtW'(p) - ExtW'(1);
    return e[AW-1:0];
  endfunction

  fenw_pkg::state_e state_q, state_d;

  logic [AW-1:0]            clr_q, clr_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic                     query_q, query_d;
  logic [DataW-1:0]         delta_q, delta_d;
  logic [DataW-1:0]         sum_q, sum_d;
  logic                     out_valid_q, out_valid_d;
  logic [DataW-1:0]         out_sum_q, out_sum_d;
  logic [fenw_pkg::IdxW-1:0] top_q;
  logic [fenw_pkg::IdxW-1:0] limit;

  logic                     in_xfer;
  logic                     out_free;
  fenw_pkg::node_info_t     node;

  // Partial sum store
  logic [DataW-1:0] mem [ENTRIES];
  logic [DataW-1:0] rdata_q;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] wr_data;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= fenw_pkg::TopIndexReset;
    end else if (cfg_we_i) begin
      top_q <= cfg_wdata_i;
    end
  end

  // Add ceiling: the smaller of the top index and the store depth
  assign limit = (32'(top_q) < 32'(ENTRIES)) ? top_q : fenw_pkg::IdxW'(ENTRIES);

  assign in_stall_o = (state_q != fenw_pkg::StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  fenw_node_step #(
    .ENTRIES(ENTRIES)
  ) u_step (
    .pos_i  (pos_q),
    .query_i(query_q),
    .limit_i(limit),
    .info_o (node)
  );

  // Walk control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    query_d     = query_q;
    delta_d     = delta_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_sum_d   = out_sum_q;
    rd_addr     = node_addr(node.next_pos);
    wr_en       = 1'b0;
    wr_addr     = node_addr(pos_q);
    wr_data     = rdata_q + delta_q;

    unique case (state_q)
      fenw_pkg::StClear: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(ENTRIES - 1)) begin
          state_d = fenw_pkg::StIdle;
        end
      end
      fenw_pkg::StIdle: begin
        // Start the first node read together with the transfer
        rd_addr = node_addr({1'b0, index_i});
        if (in_xfer) begin
          pos_d   = {1'b0, index_i};
          query_d = (action_i == fenw_pkg::ActQuery);
          delta_d = delta_i;
          sum_d   = '0;
          state_d = fenw_pkg::StWalk;
        end
      end
      fenw_pkg::StWalk: begin
        if (node.active) begin
          // Visit node: fold into the sum or write back, fetch the next one
          pos_d = node.next_pos;
          if (query_q) begin
            if (node.in_range) begin
              sum_d = sum_q + rdata_q;
            end
          end else begin
            wr_en = 1'b1;
          end
        end else if (!query_q) begin
          state_d = fenw_pkg::StIdle;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = sum_q;
          state_d     = fenw_pkg::StIdle;
        end
      end
      default: begin
        state_d = fenw_pkg::StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fenw_pkg::StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    query_q   <= query_d;
    delta_q   <= delta_d;
    sum_q     <= sum_d;
    out_sum_q <= out_sum_d;
  end

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  assign out_valid_o  = out_valid_q;
  assign prefix_sum_o = out_sum_q;

endmodule
`default_nettype wire

@@ verif/fenwick_sum_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_sum_checker
// Watches the configuration port and both channels of the binary indexed tree.
// Keeps its own copy of the partial-sum nodes and the top index, computes the
// prefix sum of every accepted query and compares each result transfer with
// the oldest pending expectation.
// ----------------------------------------------------------------------------
module fenwick_sum_checker
  import fenw_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [IdxW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     action_i,
  input  logic [IdxW-1:0]          index_i,
  input  logic signed [DataW-1:0]  delta_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DataW-1:0]  prefix_sum_i,
  output int                       err_count_o,
  output int                       pending_o
);

  typedef struct {
    logic [IdxW-1:0]         index;
    logic signed [DataW-1:0] sum;
  } query_exp_t;

  // Shadow tree, nodes numbered from 1
  logic [DataW-1:0] node_sums [1:ENTRIES];
  logic [IdxW-1:0]  top_index;
  query_exp_t       expected_sums [$];
  int               fail_cnt;

  // Point add: walk up the covering nodes, stopping at min(top, ENTRIES)
  function automatic void apply_add(int unsigned pos, logic [DataW-1:0] amount);
    int unsigned limit;
    limit = (int'(top_index) > ENTRIES) ? ENTRIES : int'(top_index);
    if (pos == 0) return;
    while (pos <= limit) begin
      node_sums[pos] = node_sums[pos] + amount;
      pos = pos + (pos & (~pos + 1));
    end
  endfunction

  // Prefix sum: walk down, nodes past the store read as zero
  function automatic logic [DataW-1:0] prefix_sum_of(int unsigned pos);
    logic [DataW-1:0] acc;
    acc = '0;
    while (pos > 0) begin
      if (pos <= ENTRIES) acc = acc + node_sums[pos];
      pos = pos - (pos & (~pos + 1));
    end
    return acc;
  endfunction

  // Monitor: result transfer first, then input transfer, then config write
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    query_exp_t head;
    query_exp_t item;
    if (!rst_ni) begin
      for (int i = 1; i <= ENTRIES; i++) node_sums[i] = '0;
      top_index = TopIndexReset;
      expected_sums.delete();
      fail_cnt = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: prefix_sum transfer with no query pending: expected none, actual %0d",
                   $time, prefix_sum_i);
          fail_cnt++;
        end else begin
          head = expected_sums.pop_front();
          if (prefix_sum_i !== head.sum) begin
            $display("%0t: prefix_sum mismatch for index %0d: expected %0d, actual %0d",
                     $time, head.index, head.sum, prefix_sum_i);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == ActQuery) begin
          item.index = index_i;
          item.sum   = prefix_sum_of(index_i);
          expected_sums = {expected_sums, item};
        end else begin
          apply_add(index_i, delta_i);
        end
      end
      if (cfg_we_i) top_index = cfg_wdata_i;
    end
    err_count_o <= fail_cnt;
    pending_o   <= expected_sums.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the binary indexed tree block. Runs a directed
// pass over the corner cases, then random add/query phases under several
// top index settings with bursty input and random output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import fenw_pkg::*;

  localparam int unsigned Entries      = EntriesDefault;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned PhaseItems   = 115;

  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic,
    StallHold
  } stall_mode_e;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [IdxW-1:0]          cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     action = ActAdd;
  logic [IdxW-1:0]          index = '0;
  logic signed [DataW-1:0]  delta = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DataW-1:0]  prefix_sum;
  int                       err_count;
  int                       pending;
  logic [IdxW-1:0]          cur_top = TopIndexReset;

  fenwick_point_add_prefix_sum #(.ENTRIES(Entries)) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .index_i      (index),
    .delta_i      (delta),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .prefix_sum_o (prefix_sum)
  );

  fenwick_sum_checker #(.ENTRIES(Entries)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .index_i      (index),
    .delta_i      (delta),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .prefix_sum_i (prefix_sum),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Output stall pattern, switching between randomly chosen modes
  initial begin : stall_pattern
    stall_mode_e mode;
    int unsigned span;
    int unsigned tick;
    tick = 0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 4));
      span = (mode == StallHold) ? $urandom_range(10, 40) : $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          StallNone:     out_stall <= 1'b0;
          StallLight:    out_stall <= ($urandom_range(0, 3) == 0);
          StallHeavy:    out_stall <= ($urandom_range(0, 3) != 0);
          StallPeriodic: out_stall <= ((tick % 5) < 2);
          default:       out_stall <= 1'b1;
        endcase
      end
    end
  end

  // One input transfer; returns at the accepting edge
  task automatic send_item(logic act, logic [IdxW-1:0] idx, logic [DataW-1:0] dlt);
    in_valid <= 1'b1;
    action   <= act;
    index    <= idx;
    delta    <= dlt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every query has been answered
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Drain, then let a trailing add walk finish before touching the register
  task automatic settle();
    wait_results();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_top(logic [IdxW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_top = value;
  endtask

  // Random item, mostly indices inside the active range
  function automatic void pick_item(output logic act, output logic [IdxW-1:0] idx,
                                    output logic [DataW-1:0] dlt);
    int unsigned span;
    int unsigned r;
    span = (cur_top == 0 || int'(cur_top) > Entries) ? Entries : int'(cur_top);
    act  = ($urandom_range(0, 1) == 0) ? ActAdd : ActQuery;
    r    = $urandom_range(0, 99);
    if (r < 5)       idx = '0;
    else if (r < 12) idx = IdxW'($urandom_range(0, 2047));
    else if (r < 16) idx = IdxW'(span);
    else             idx = IdxW'($urandom_range(1, span));
    r = $urandom_range(0, 99);
    case (r % 4)
      0: dlt = 32'h7FFF_FFFF;
      1: dlt = 32'h8000_0000;
      2: dlt = 32'hFFFF_FFFF;
      default: dlt = '0;
    endcase
    if (r >= 40)      dlt = $urandom;
    else if (r >= 10) dlt = DataW'(int'($urandom_range(0, 200)) - 100);
  endfunction

  // Random phase: bursts with gaps, or back-to-back when steady
  task automatic run_random(int unsigned count, bit steady);
    int unsigned burst_left;
    logic act;
    logic [IdxW-1:0] idx;
    logic [DataW-1:0] dlt;
    burst_left = $urandom_range(1, 24);
    for (int unsigned n = 0; n < count; n++) begin
      pick_item(act, idx, dlt);
      send_item(act, idx, dlt);
      if ($urandom_range(0, 59) == 0) begin
        wait_results();
      end else if (!steady) begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          pause(($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6));
        end
      end
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [IdxW-1:0] phase_top [10];
    phase_top = '{IdxW'(1024), IdxW'(1), IdxW'(2047), IdxW'($urandom_range(1, 1024)),
                  IdxW'(0), IdxW'($urandom_range(1, 16)), IdxW'(512),
                  IdxW'($urandom_range(1, 1024)), IdxW'(1024), IdxW'($urandom_range(2, 1023))};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset top index: empty prefix, ignored add at zero, wrap, far nodes
    send_item(ActQuery, IdxW'(0), '0);
    send_item(ActAdd,   IdxW'(0), DataW'(5));
    send_item(ActQuery, IdxW'(1024), '0);
    send_item(ActAdd,   IdxW'(1), 32'h7FFF_FFFF);
    send_item(ActAdd,   IdxW'(1), DataW'(1));
    send_item(ActQuery, IdxW'(1), '0);
    send_item(ActAdd,   IdxW'(1024), 32'hFFFF_FFFF);
    send_item(ActQuery, IdxW'(1024), '0);
    send_item(ActAdd,   IdxW'(1023), 32'h8000_0000);
    send_item(ActQuery, IdxW'(1023), '0);
    send_item(ActQuery, IdxW'(2047), '0);        // beyond the store
    send_item(ActAdd,   IdxW'(2047), DataW'(1234)); // above the top
    send_item(ActAdd,   IdxW'(512), DataW'(12345));
    send_item(ActQuery, IdxW'(511), '0);
    send_item(ActQuery, IdxW'(512), '0);
    settle();

    // Top of one: add above the top is dropped
    write_top(IdxW'(1));
    send_item(ActAdd,   IdxW'(1), DataW'(3));
    send_item(ActAdd,   IdxW'(2), DataW'(9));
    send_item(ActQuery, IdxW'(2), '0);
    settle();

    // Top of zero: every add ignored
    write_top(IdxW'(0));
    send_item(ActAdd,   IdxW'(5), DataW'(100));
    send_item(ActQuery, IdxW'(8), '0);
    settle();

    // Top past the store: adds stop at the last node
    write_top(IdxW'(2047));
    send_item(ActAdd,   IdxW'(1000), DataW'(-7));
    send_item(ActQuery, IdxW'(2047), '0);
    settle();

    // Top lowered after adds: higher nodes keep their contents
    write_top(IdxW'(100));
    send_item(ActAdd,   IdxW'(64), DataW'(11));
    send_item(ActQuery, IdxW'(128), '0);
    send_item(ActQuery, IdxW'(100), '0);
    settle();

    // Random phases, one top index each
    for (int p = 0; p < 10; p++) begin
      write_top(phase_top[p]);
      run_random(PhaseItems, (p == 3) || (p == 8));
      settle();
    end

    if (err_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
